// ----- design/b64h_pkg.sv -----
// Shared types, codes and character tables for the base64 and hex stream codec.
`default_nettype none
package b64h_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;
   localparam int BEAT_CNT_W  = 3;
   localparam int MAX_BEATS   = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_OPERATION = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHABET  = 2'd1;

   typedef enum logic [1:0] {
      OP_B64_ENCODE = 2'd0,
      OP_B64_DECODE = 2'd1,
      OP_HEX_ENCODE = 2'd2
   } op_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic       out_error;
   } rsp_payload_type;

   typedef struct packed {
      logic [MAX_BEATS-1:0][7:0] beats;
      logic [BEAT_CNT_W-1:0]     count;
      logic                      last;
      logic                      error;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } job_push_type;

   function automatic logic [7:0] pad_char(input logic alt);
      pad_char = alt ? 8'h2e : 8'h3d;
   endfunction

   function automatic logic [7:0] enc_char(input logic [5:0] v, input logic alt);
      logic [7:0] c;
      c = 8'h00;
      if (v < 6'd26) begin
         c = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         c = 8'h61 + {2'b00, v - 6'd26};
      end else if (v < 6'd62) begin
         c = 8'h30 + {2'b00, v - 6'd52};
      end else if (v == 6'd62) begin
         c = alt ? 8'h2d : 8'h2b;
      end else begin
         c = alt ? 8'h5f : 8'h2f;
      end
      enc_char = c;
   endfunction

   // Bit 6 set means the character lies outside the alphabet.
   function automatic logic [6:0] dec_val(input logic [7:0] c, input logic alt);
      logic [6:0] v;
      v = 7'h40;
      if (c >= 8'h41 && c <= 8'h5a) begin
         v = 7'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7a) begin
         v = 7'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         v = 7'(c - 8'h30 + 8'd52);
      end else if (c == (alt ? 8'h2d : 8'h2b)) begin
         v = 7'd62;
      end else if (c == (alt ? 8'h5f : 8'h2f)) begin
         v = 7'd63;
      end
      dec_val = v;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      hex_char = (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h61 + {4'h0, n - 4'd10});
   endfunction

endpackage
`default_nettype wire

// ----- design/b64h_front.sv -----
// Front end: configuration registers, group state and building of output jobs.
`default_nettype none
module b64h_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire b64h_pkg::req_payload_type       req_payload,
   input  wire logic                            csr_valid,
   input  wire logic [b64h_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [b64h_pkg::CSR_DATA_W-1:0] csr_data,
   input  wire logic                            queue_full,
   output b64h_pkg::job_push_type               push
);
   import b64h_pkg::*;

   op_type      operation_ff, operation_in;
   logic        alphabet_ff, alphabet_in;
   logic [23:0] gbuf_ff, gbuf_in;
   logic [1:0]  gcnt_ff, gcnt_in;
   logic [1:0]  pad_ff, pad_in;
   logic        err_ff, err_in;

   logic        accept;
   logic        is_pad;
   logic [6:0]  dv;
   logic [5:0]  sextet;
   logic [1:0]  pad_n;
   logic        err_n;
   logic [23:0] buf_n;
   logic [23:0] full;
   logic [2:0]  n_enc;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign is_pad    = (req_payload.in_byte == pad_char(alphabet_ff));
   assign dv        = dec_val(req_payload.in_byte, alphabet_ff);

   always_comb begin
      operation_in = operation_ff;
      alphabet_in  = alphabet_ff;
      gbuf_in      = gbuf_ff;
      gcnt_in      = gcnt_ff;
      pad_in       = pad_ff;
      err_in       = err_ff;
      push         = '0;
      sextet       = '0;
      pad_n        = pad_ff;
      err_n        = err_ff;
      buf_n        = gbuf_ff;
      full         = gbuf_ff;
      n_enc        = {1'b0, gcnt_ff} + 3'd1;

      if (accept) begin
         case (operation_ff)
            OP_B64_ENCODE: begin
               buf_n = {gbuf_ff[15:0], req_payload.in_byte};
               case (n_enc)
                  3'd1:    full = {buf_n[7:0], 16'h0000};
                  3'd2:    full = {buf_n[15:0], 8'h00};
                  default: full = buf_n;
               endcase
               if (n_enc >= 3'd3 || req_payload.in_last) begin
                  push.valid          = 1'b1;
                  push.job.beats[0]   = enc_char(full[23:18], alphabet_ff);
                  push.job.beats[1]   = enc_char(full[17:12], alphabet_ff);
                  push.job.beats[2]   = (n_enc >= 3'd2) ? enc_char(full[11:6], alphabet_ff)
                                                        : pad_char(alphabet_ff);
                  push.job.beats[3]   = (n_enc == 3'd3) ? enc_char(full[5:0], alphabet_ff)
                                                        : pad_char(alphabet_ff);
                  push.job.count      = 3'd4;
                  push.job.last       = req_payload.in_last;
                  gbuf_in             = '0;
                  gcnt_in             = '0;
               end else begin
                  gbuf_in = buf_n;
                  gcnt_in = n_enc[1:0];
               end
               if (req_payload.in_last) begin
                  pad_in = '0;
                  err_in = 1'b0;
               end
            end
            OP_B64_DECODE: begin
               if (is_pad || pad_ff != 2'd0) begin
                  if (!is_pad) begin
                     err_n = 1'b1;
                  end
                  if (pad_ff != 2'd3) begin
                     pad_n = pad_ff + 2'd1;
                  end
               end else if (dv[6]) begin
                  err_n = 1'b1;
               end else begin
                  sextet = dv[5:0];
               end
               if (pad_n == 2'd3) begin
                  err_n = 1'b1;
               end
               buf_n = {gbuf_ff[17:0], sextet};
               if (gcnt_ff == 2'd3) begin
                  if (req_payload.in_last) begin
                     push.job.count = (pad_n == 2'd0) ? 3'd3 : (pad_n == 2'd1) ? 3'd2 : 3'd1;
                  end else begin
                     push.job.count = 3'd3;
                     if (pad_n != 2'd0) begin
                        err_n = 1'b1;
                     end
                  end
                  push.valid        = 1'b1;
                  push.job.beats[0] = buf_n[23:16];
                  push.job.beats[1] = buf_n[15:8];
                  push.job.beats[2] = buf_n[7:0];
                  push.job.last     = req_payload.in_last;
                  push.job.error    = err_n;
                  gbuf_in           = '0;
                  gcnt_in           = '0;
                  pad_in            = '0;
                  err_in            = req_payload.in_last ? 1'b0 : err_n;
               end else if (req_payload.in_last) begin
                  push.valid     = 1'b1;
                  push.job.count = 3'd1;
                  push.job.last  = 1'b1;
                  push.job.error = 1'b1;
                  gbuf_in        = '0;
                  gcnt_in        = '0;
                  pad_in         = '0;
                  err_in         = 1'b0;
               end else begin
                  gbuf_in = buf_n;
                  gcnt_in = gcnt_ff + 2'd1;
                  pad_in  = pad_n;
                  err_in  = err_n;
               end
            end
            OP_HEX_ENCODE: begin
               push.valid        = 1'b1;
               push.job.beats[0] = hex_char(req_payload.in_byte[7:4]);
               push.job.beats[1] = hex_char(req_payload.in_byte[3:0]);
               push.job.count    = 3'd2;
               push.job.last     = req_payload.in_last;
               if (req_payload.in_last) begin
                  gbuf_in = '0;
                  gcnt_in = '0;
                  pad_in  = '0;
                  err_in  = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end

      if (csr_valid) begin
         case (csr_index)
            CSR_OPERATION: begin
               operation_in = op_type'(csr_data[1:0]);
               gbuf_in      = '0;
               gcnt_in      = '0;
               pad_in       = '0;
               err_in       = 1'b0;
            end
            CSR_ALPHABET: begin
               alphabet_in = csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         operation_ff <= OP_B64_ENCODE;
         alphabet_ff  <= 1'b0;
         gbuf_ff      <= '0;
         gcnt_ff      <= '0;
         pad_ff       <= '0;
         err_ff       <= 1'b0;
      end else begin
         operation_ff <= operation_in;
         alphabet_ff  <= alphabet_in;
         gbuf_ff      <= gbuf_in;
         gcnt_ff      <= gcnt_in;
         pad_ff       <= pad_in;
         err_ff       <= err_in;
      end
   end

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> (push.job.count != 3'd0 && push.job.count <= 3'(MAX_BEATS)))
      else $error("job pushed with an impossible beat count");

endmodule
`default_nettype wire

// ----- design/b64h_queue.sv -----
// Short job queue between the front end and the output sequencer.
`default_nettype none
module b64h_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire b64h_pkg::job_push_type push,
   output logic                        full,
   output logic                        head_valid,
   output b64h_pkg::job_type           head,
   input  wire logic                   pop
);
   import b64h_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !full)
      else $error("job pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("job popped from an empty queue");

endmodule
`default_nettype wire

// ----- design/b64h_back.sv -----
// Back end: splits each job into result beats behind an output register.
`default_nettype none
module b64h_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  head_valid,
   input  wire b64h_pkg::job_type     head,
   output logic                       pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output b64h_pkg::rsp_payload_type  rsp_payload
);
   import b64h_pkg::*;

   job_type          job_ff, job_in;
   logic             job_valid_ff, job_valid_in;
   logic [1:0]       beat_ff, beat_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_ff, rsp_in;
   logic             advance;
   logic             final_beat;

   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign final_beat = ({1'b0, beat_ff} == job_ff.count - 3'd1);
   assign pop        = head_valid && (!job_valid_ff || (advance && final_beat));

   always_comb begin
      job_in       = job_ff;
      job_valid_in = job_valid_ff;
      beat_in      = beat_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in = job_valid_ff;
         if (job_valid_ff) begin
            rsp_in.out_byte  = job_ff.beats[beat_ff];
            rsp_in.out_last  = final_beat && job_ff.last;
            rsp_in.out_error = job_ff.error;
            beat_in          = beat_ff + 2'd1;
            if (final_beat) begin
               job_valid_in = 1'b0;
            end
         end
      end
      if (pop) begin
         job_in       = head;
         job_valid_in = 1'b1;
         beat_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         beat_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         beat_ff      <= beat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_beat_in_job: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff |-> ({1'b0, beat_ff} < job_ff.count))
      else $error("beat index runs past the end of its job");

endmodule
`default_nettype wire

// ----- design/base64_hex_stream_codec.sv -----
// Top level of the streaming base64 encode, base64 decode and hex encode codec.
// Bytes arrive on the req_ channel, one per beat, with in_last on the final byte of a
// stream; the converted characters or bytes leave on the rsp_ channel, one per beat.
// A beat moves when valid is high and stall is low; the receiver drives stall.
// The csr_ port writes operation (index 0) and alphabet (index 1); csr_ready is always
// high, and a write to operation clears any open group.
// The first result of an item passes the job queue, the job register and the output
// register of the back end on its way to rsp_. One result beat leaves per cycle while
// the receiver does not stall; hex encode gives two beats per byte, base64 encode four
// per group of up to three bytes. The front end takes a new byte every cycle while the
// job queue (QUEUE_DEPTH jobs) has room.
// When the receiver stalls, the output register holds its beat, the queue fills, and
// req_stall rises once it is full; nothing is lost.
// Synchronous reset empties the queue and output register and returns operation and
// alphabet to base64 encode with the standard alphabet.
`default_nettype none
module base64_hex_stream_codec #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire b64h_pkg::req_payload_type        req_payload,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output b64h_pkg::rsp_payload_type             rsp_payload,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [b64h_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [b64h_pkg::CSR_DATA_W-1:0]  csr_data
);
   import b64h_pkg::*;

   job_push_type push;
   logic         queue_full;
   logic         head_valid;
   job_type      head;
   logic         pop;

   assign csr_ready = 1'b1;

   b64h_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .csr_valid   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .queue_full  (queue_full),
      .push        (push)
   );

   b64h_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (queue_full),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   b64h_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

// ----- verif/tb_codec_pkg.sv -----
// Scoreboard class and character helpers for the base64 and hex codec testbench.
`timescale 1ns / 1ps
package tb_codec_pkg;
   import b64h_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;

   localparam string STD_GLYPHS =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
   localparam string ALT_GLYPHS =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";
   localparam string HEX_GLYPHS = "0123456789abcdef";

   function automatic logic [7:0] sextet_char(input logic [5:0] v, input logic alt);
      string glyphs;
      glyphs = alt ? ALT_GLYPHS : STD_GLYPHS;
      return glyphs[v];
   endfunction

   function automatic int char_sextet(input logic [7:0] c, input logic alt);
      for (int i = 0; i < 64; i++) begin
         if (sextet_char(6'(i), alt) == c) return i;
      end
      return 64;
   endfunction

   function automatic logic [7:0] pad_glyph(input logic alt);
      return alt ? "." : "=";
   endfunction

   class codec_scoreboard;
      logic [1:0]      op_mode;
      logic            alt_set;
      logic [23:0]     grp_bits;
      int              grp_fill;
      int              pad_seen;
      logic            err_sticky;
      rsp_payload_type expected_q[$];
      int              mismatches;
      int              items_seen[4];
      int              results_checked;
      int              error_results;

      function new();
         op_mode = OP_B64_ENCODE;
         alt_set = 1'b0;
         clear_group();
         mismatches = 0;
         results_checked = 0;
         error_results = 0;
         foreach (items_seen[i]) items_seen[i] = 0;
      endfunction

      function void clear_group();
         grp_bits = '0;
         grp_fill = 0;
         pad_seen = 0;
         err_sticky = 1'b0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function int coded_items();
         return items_seen[0] + items_seen[1] + items_seen[2];
      endfunction

      function void write_reg(input logic [CSR_INDEX_W-1:0] idx,
                              input logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_OPERATION) begin
            op_mode = data[1:0];
            clear_group();
         end else if (idx == CSR_ALPHABET) begin
            alt_set = data[0];
         end
      endfunction

      function void expect_beat(input logic [7:0] b, input logic l, input logic e);
         rsp_payload_type r;
         r.out_byte = b;
         r.out_last = l;
         r.out_error = e;
         expected_q.push_back(r);
      endfunction

      function void encode_byte(input logic [7:0] b, input logic l);
         logic [23:0] full;
         grp_bits = {grp_bits[15:0], b};
         grp_fill++;
         if (grp_fill == 3 || l) begin
            full = grp_bits << (8 * (3 - grp_fill));
            expect_beat(sextet_char(full[23:18], alt_set), 1'b0, 1'b0);
            expect_beat(sextet_char(full[17:12], alt_set), 1'b0, 1'b0);
            expect_beat(grp_fill >= 2 ? sextet_char(full[11:6], alt_set) : pad_glyph(alt_set),
                        1'b0, 1'b0);
            expect_beat(grp_fill == 3 ? sextet_char(full[5:0], alt_set) : pad_glyph(alt_set),
                        l, 1'b0);
            grp_bits = '0;
            grp_fill = 0;
         end
         if (l) clear_group();
      endfunction

      function void decode_char(input logic [7:0] c, input logic l);
         logic is_pad;
         int   v;
         int   nb;
         is_pad = (c == pad_glyph(alt_set));
         if (is_pad || pad_seen > 0) begin
            if (!is_pad) err_sticky = 1'b1;
            if (pad_seen < 3) pad_seen++;
            v = 0;
         end else begin
            v = char_sextet(c, alt_set);
            if (v > 63) begin
               err_sticky = 1'b1;
               v = 0;
            end
         end
         if (pad_seen >= 3) err_sticky = 1'b1;
         grp_bits = {grp_bits[17:0], 6'(v)};
         if (grp_fill == 3) begin
            nb = 3;
            if (l) begin
               nb = (pad_seen == 0) ? 3 : (pad_seen == 1) ? 2 : 1;
            end else if (pad_seen > 0) begin
               err_sticky = 1'b1;
            end
            for (int k = 0; k < nb; k++) begin
               expect_beat(grp_bits[(16 - 8 * k) +: 8], l && (k == nb - 1), err_sticky);
            end
            grp_bits = '0;
            grp_fill = 0;
            pad_seen = 0;
            if (l) clear_group();
         end else begin
            grp_fill++;
            if (l) begin
               expect_beat(8'h00, 1'b1, 1'b1);
               clear_group();
            end
         end
      endfunction

      function void note_input(input logic [7:0] b, input logic l);
         items_seen[op_mode]++;
         case (op_mode)
            OP_B64_ENCODE: encode_byte(b, l);
            OP_B64_DECODE: decode_char(b, l);
            OP_HEX_ENCODE: begin
               expect_beat(HEX_GLYPHS[b[7:4]], 1'b0, 1'b0);
               expect_beat(HEX_GLYPHS[b[3:0]], l, 1'b0);
               if (l) clear_group();
            end
            default: ;
         endcase
      endfunction

      function void check_result(input rsp_payload_type got);
         rsp_payload_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result beat: byte %h last %b error %b",
                        got.out_byte, got.out_last, got.out_error);
            return;
         end
         want = expected_q.pop_front();
         results_checked++;
         if (got.out_error) error_results++;
         if (got.out_byte !== want.out_byte || got.out_last !== want.out_last ||
             got.out_error !== want.out_error) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Mismatch on result %0d: expected byte %h last %b error %b,",
                        results_checked, want.out_byte, want.out_last, want.out_error,
                        " got byte %h last %b error %b",
                        got.out_byte, got.out_last, got.out_error);
         end
      endfunction
   endclass

endpackage

// ----- verif/tb_top.sv -----
// Top-level testbench for the streaming base64 and hex codec.
`timescale 1ns / 1ps
module tb_top;
   import b64h_pkg::*;
   import tb_codec_pkg::*;

   localparam int SETTLE_CYCLES = 8;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_payload_type        req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_payload_type        rsp_payload;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   codec_scoreboard board;
   bit calm = 1'b0;
   bit sender_gaps = 1'b1;
   int stall_left = 0;
   int run_left = 0;

   base64_hex_stream_codec DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_payload);
      if (reset || calm) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         run_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (run_left > 0) begin
         run_left--;
         rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 2) == 0) begin
         stall_left = $urandom_range(0, 11);
         rsp_stall <= 1'b1;
      end else begin
         run_left = $urandom_range(0, 40);
         rsp_stall <= 1'b0;
      end
   end

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   task automatic send(input logic [7:0] b, input logic l);
      req_valid <= 1'b1;
      req_payload <= {b, l};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_input(b, l);
      if (!calm && sender_gaps && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end else if (!calm && $urandom_range(0, 59) == 0) begin
         hold_until_drained();
      end
   endtask

   task automatic settle();
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.write_reg(idx, data);
   endtask

   task automatic configure(input logic [7:0] op_data, input logic [7:0] alpha_data,
                            input bit spare);
      write_csr(CSR_OPERATION, op_data);
      write_csr(CSR_ALPHABET, alpha_data);
      if (spare) write_csr($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B, 8'($urandom));
      csr_valid <= 1'b0;
   endtask

   task automatic send_text(input string s, input logic l);
      for (int i = 0; i < s.len(); i++) send(s[i], l && (i == s.len() - 1));
   endtask

   task automatic send_decode_stream();
      logic [7:0] chars[$];
      int groups;
      int shape;
      groups = $urandom_range(1, 4);
      for (int i = 0; i < 4 * groups; i++)
         chars.push_back(sextet_char(6'($urandom_range(0, 63)), board.alt_set));
      for (int i = $urandom_range(0, 2); i > 0; i--)
         chars[chars.size() - i] = pad_glyph(board.alt_set);
      shape = $urandom_range(0, 9);
      if (shape == 6) begin
         chars[$urandom_range(0, chars.size() - 1)] = 8'($urandom);
      end else if (shape == 7) begin
         repeat ($urandom_range(1, 3)) void'(chars.pop_back());
      end else if (shape == 8) begin
         chars[$urandom_range(0, chars.size() - 1)] = pad_glyph(board.alt_set);
      end else if (shape == 9) begin
         chars.delete();
         repeat ($urandom_range(1, 12))
            chars.push_back($urandom_range(0, 3) == 0 ? pad_glyph(board.alt_set)
                                                     : 8'($urandom));
      end
      for (int i = 0; i < chars.size(); i++) send(chars[i], i == chars.size() - 1);
   endtask

   task automatic send_byte_stream(input int max_len);
      int len;
      len = $urandom_range(1, max_len);
      for (int i = 0; i < len; i++) send(8'($urandom), i == len - 1);
   endtask

   task automatic send_open_group(input logic [1:0] op);
      repeat ($urandom_range(1, 3)) begin
         if (op == OP_B64_DECODE)
            send(sextet_char(6'($urandom_range(0, 63)), board.alt_set), 1'b0);
         else
            send(8'($urandom), 1'b0);
      end
   endtask

   initial begin
      logic [1:0] op;
      int pick;
      board = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      configure(8'(OP_B64_ENCODE), 8'h00, 1'b0);
      send(8'h00, 1'b0);
      send(8'hff, 1'b0);
      send(8'h7f, 1'b0);
      hold_until_drained();
      send(8'h80, 1'b1);
      settle();
      configure(8'hfc, 8'hff, 1'b1);
      send(8'hfb, 1'b0);
      send(8'hff, 1'b1);
      settle();
      configure(8'hfe, 8'h00, 1'b0);
      send(8'h00, 1'b0);
      send(8'hff, 1'b1);
      settle();
      configure(8'(OP_B64_DECODE), 8'hfe, 1'b0);
      send_text("*A=xA", 1'b1);
      send_text("QU", 1'b0);
      settle();
      write_csr(CSR_ALPHABET, 8'h01);
      csr_valid <= 1'b0;
      send_text("-.", 1'b1);
      send_text("Q...", 1'b1);
      send_text("_-", 1'b0);
      settle();
      configure(8'(OP_B64_DECODE), 8'h00, 1'b0);
      send_text("TWFu", 1'b1);
      settle();
      configure(8'hff, 8'h00, 1'b0);
      send(8'h5a, 1'b1);

      while (board.coded_items() < 390) begin
         calm = (board.coded_items() >= 330);
         settle();
         pick = $urandom_range(0, 19);
         op = (pick < 6) ? OP_B64_ENCODE : (pick < 13) ? OP_B64_DECODE :
              (pick < 19) ? OP_HEX_ENCODE : OP_UNUSED;
         configure({6'($urandom), op}, {7'($urandom), 1'($urandom)},
                   $urandom_range(0, 3) == 0);
         sender_gaps = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(1, 4)) begin
            case (op)
               OP_B64_ENCODE: send_byte_stream(10);
               OP_B64_DECODE: send_decode_stream();
               OP_HEX_ENCODE: send_byte_stream(6);
               default:       send(8'($urandom), 1'($urandom));
            endcase
         end
         if ((op == OP_B64_ENCODE || op == OP_B64_DECODE) && $urandom_range(0, 5) == 0)
            send_open_group(op);
      end

      hold_until_drained();
      repeat (20) @(posedge clock);
      $display("Streamed %0d base64 encode, %0d decode, %0d hex and %0d unused-mode bytes.",
               board.items_seen[0], board.items_seen[1], board.items_seen[2],
               board.items_seen[3]);
      $display("Checked %0d result beats, %0d flagged with a decode error; %0d mismatches.",
               board.results_checked, board.error_results, board.mismatches);
      if (board.mismatches == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Run timed out with %0d result beats still outstanding.", board.pending());
      $display("tb_top: FAIL");
      $finish;
   end

endmodule
